// File: design/ibh_pkg.sv
// Shared constants for the indexed binary heap core.
package ibh_pkg;
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	localparam int NODE_W  = 10;
	localparam int REQ_PRIO_W = 16;
	localparam int COUNT_W = 11;
endpackage

// File: design/indexed_binary_heap_core.sv
// Indexed binary max-heap core: heap arrays, position map and presence bits in RAM.
//
// Usage: drive operation, node_id and priority_req with start high while busy
// is low; the request is taken at that edge and busy rises. One result comes
// back per request on out_node, out_priority, present, entry_count and status,
// marked by done for exactly one cycle; it cannot be stalled.
// Operations: insert, remove highest, raise priority, query.
// Query and error answers pass only the decode and lookup states. A sift-up
// level reads the parent, compares and writes the pair back. A sift-down level
// reads the left child and any right child, picks the larger, compares and
// writes back. Insert, update and remove grow with the number of levels sifted;
// the sift sequencer and the single port of the slot memory set their length.
// The next request is accepted in the cycle after done.
// Reset: a clearing pass runs over the presence memory, one entry a cycle,
// with busy high; the heap count starts at zero.
module indexed_binary_heap_core #(
	parameter int CAPACITY      = 1024,
	parameter int ID_COUNT      = 1024,
	parameter int PRIORITY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         operation,
	input  logic [ibh_pkg::NODE_W-1:0]         node_id,
	input  logic [ibh_pkg::REQ_PRIO_W-1:0]     priority_req,
	output logic                               done,
	output logic [ibh_pkg::NODE_W-1:0]         out_node,
	output logic [ibh_pkg::REQ_PRIO_W-1:0]     out_priority,
	output logic                               present,
	output logic [ibh_pkg::COUNT_W-1:0]        entry_count,
	output logic [1:0]                         status
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = PRIORITY_BITS;
	localparam int EW = IW + PW;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LOOK  = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_RTOP  = 4'd4;
	localparam logic [3:0] S_RLAST = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_CMP   = 4'd7;
	localparam logic [3:0] S_UP_R  = 4'd8;
	localparam logic [3:0] S_UP_C  = 4'd9;
	localparam logic [3:0] S_DN_R  = 4'd10;
	localparam logic [3:0] S_DN_C  = 4'd11;
	localparam logic [3:0] S_DN_D  = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;
	localparam logic [3:0] S_UPD   = 4'd14;

	// slot memory: {id, prio}; single port
	logic [EW-1:0] slot_mem [CAPACITY];
	logic [AW-1:0] pos_mem [ID_COUNT];
	logic          pres_mem [ID_COUNT];

	logic          slot_we;
	logic [AW-1:0] slot_addr;
	logic [EW-1:0] slot_wd, slot_rd_q;
	logic          pos_we;
	logic [IW-1:0] pos_addr;
	logic [AW-1:0] pos_wd, pos_rd_q;
	logic          pres_we;
	logic [IW-1:0] pres_addr;
	logic          pres_wd, pres_rd_q;

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_addr] <= slot_wd;
		slot_rd_q <= slot_mem[slot_addr];
	end
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_addr] <= pos_wd;
		pos_rd_q <= pos_mem[pos_addr];
	end
	always_ff @(posedge clk) begin
		if (pres_we) pres_mem[pres_addr] <= pres_wd;
		pres_rd_q <= pres_mem[pres_addr];
	end

	logic [3:0]    state_q, state_d;
	logic [IW:0]   clr_q;
	logic [CW-1:0] fill_q;
	logic [1:0]    op_q;
	logic [ibh_pkg::NODE_W-1:0] id_q;
	logic [PW-1:0] prio_q;
	logic          id_ok_q;
	logic [AW-1:0] cur_q, oth_q;
	logic [EW-1:0] cur_e_q, oth_e_q, rgt_e_q;
	logic [1:0]    sub_q;
	logic [1:0]    st_q;
	logic [ibh_pkg::NODE_W-1:0] onode_q;
	logic [PW-1:0] oprio_q;
	logic          opres_q;

	logic [AW:0] lchild, rchild;
	assign lchild = {cur_q, 1'b1};
	assign rchild = {cur_q, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};

	logic [AW-1:0] parent;
	assign parent = AW'((cur_q - AW'(1)) >> 1);

	logic [IW-1:0] id_idx;
	assign id_idx = IW'(id_q);

	// a swap step writes both slots; sub_q sequences the two slot writes, each with its position write
	always_comb begin
		slot_we = 1'b0; slot_addr = cur_q; slot_wd = cur_e_q;
		pos_we = 1'b0; pos_addr = id_idx; pos_wd = cur_q;
		pres_we = 1'b0; pres_addr = id_idx; pres_wd = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				pres_we = 1'b1; pres_addr = clr_q[IW-1:0];
			end
			S_IDLE: pres_addr = IW'(node_id);
			S_LOOK: begin
				if (op_q == ibh_pkg::OP_INSERT && st_q == ibh_pkg::ST_OK) begin
					slot_we = 1'b1; slot_addr = AW'(fill_q);
					slot_wd = {id_idx, prio_q};
					pos_we = 1'b1; pos_wd = AW'(fill_q);
					pres_we = 1'b1; pres_wd = 1'b1;
				end
			end
			S_RTOP: slot_addr = '0;
			S_RLAST: begin
				slot_addr = AW'(fill_q);
				pres_we = (sub_q == 2'd1); pres_addr = cur_e_q[EW-1:PW];
			end
			S_UPD: begin
				slot_addr = pos_rd_q;
			end
			S_RD: begin
				slot_we = (sub_q == 2'd1); slot_addr = cur_q; slot_wd = cur_e_q;
				pos_we = (sub_q == 2'd1); pos_addr = cur_e_q[EW-1:PW]; pos_wd = cur_q;
			end
			S_UP_R: slot_addr = parent;
			S_DN_R: slot_addr = (sub_q == 2'd0) ? lchild[AW-1:0] : rchild[AW-1:0];
			S_CMP: begin
				// write swapped pair
				if (sub_q == 2'd0) begin
					slot_we = 1'b1; slot_addr = cur_q; slot_wd = oth_e_q;
					pos_we = 1'b1; pos_addr = oth_e_q[EW-1:PW]; pos_wd = cur_q;
				end else begin
					slot_we = 1'b1; slot_addr = oth_q; slot_wd = cur_e_q;
					pos_we = 1'b1; pos_addr = cur_e_q[EW-1:PW]; pos_wd = oth_q;
				end
			end
			default: ;
		endcase
	end

	logic rgt_ok;
	assign rgt_ok = ({1'b0, rchild} < (AW+2)'(fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			fill_q <= '0;
			sub_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'(ID_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					state_q <= S_DEC;
					op_q <= operation; id_q <= node_id;
					prio_q <= PW'(priority_req);
					id_ok_q <= ({22'd0, node_id} < 32'(ID_COUNT));
					sub_q <= '0;
				end
				S_DEC: begin
					// presence of id_q now valid
					state_q <= S_LOOK;
					onode_q <= id_q; oprio_q <= '0; opres_q <= 1'b0;
					st_q <= ibh_pkg::ST_OK;
					unique case (op_q)
						ibh_pkg::OP_INSERT:
							if (!id_ok_q || fill_q >= CW'(CAPACITY) || pres_rd_q)
								st_q <= ibh_pkg::ST_FULL;
						ibh_pkg::OP_REMOVE:
							if (fill_q == '0) st_q <= ibh_pkg::ST_EMPTY;
						ibh_pkg::OP_UPDATE:
							if (!id_ok_q || !pres_rd_q) st_q <= ibh_pkg::ST_ABSENT;
						default: opres_q <= id_ok_q && pres_rd_q;
					endcase
				end
				S_LOOK: begin
					state_q <= S_DONE;
					if (st_q == ibh_pkg::ST_OK) begin
						unique case (op_q)
							ibh_pkg::OP_INSERT: begin
								cur_q <= AW'(fill_q);
								cur_e_q <= {id_idx, prio_q};
								fill_q <= fill_q + 1'b1;
								sub_q <= '0;
								state_q <= S_UP_R;
							end
							ibh_pkg::OP_REMOVE: begin
								fill_q <= fill_q - 1'b1;
								sub_q <= '0;
								state_q <= S_RTOP;
							end
							ibh_pkg::OP_UPDATE: state_q <= S_UPD;
							default: ;
						endcase
					end
				end
				S_UPD: begin
					cur_q <= pos_rd_q;
					cur_e_q <= {id_idx, prio_q};
					sub_q <= '0;
					state_q <= S_RD;
				end
				S_RTOP: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						cur_e_q <= slot_rd_q;
						onode_q <= ibh_pkg::NODE_W'(slot_rd_q[EW-1:PW]);
						oprio_q <= slot_rd_q[PW-1:0];
						sub_q <= '0;
						state_q <= S_RLAST;
					end
				end
				S_RLAST: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						sub_q <= '0;
						if (fill_q == '0) state_q <= S_DONE;
						else begin
							cur_q <= '0;
							cur_e_q <= slot_rd_q;
							state_q <= S_RD;
							op_q <= ibh_pkg::OP_REMOVE;
						end
					end
				end
				S_RD: begin
					// write cur entry at cur slot, then start sift
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						sub_q <= '0;
						state_q <= (op_q == ibh_pkg::OP_REMOVE) ? S_DN_R : S_UP_R;
					end
				end
				S_UP_R: begin
					if (cur_q == '0) state_q <= S_DONE;
					else begin
						sub_q <= sub_q + 1'b1;
						if (sub_q == 2'd1) begin
							sub_q <= '0;
							oth_q <= parent; oth_e_q <= slot_rd_q;
							state_q <= S_UP_C;
						end
					end
				end
				S_UP_C: begin
					if (cur_e_q[PW-1:0] > oth_e_q[PW-1:0]) state_q <= S_CMP;
					else state_q <= S_DONE;
				end
				S_DN_R: begin
					if ({1'b0, lchild} >= (AW+2)'(fill_q)) state_q <= S_DONE;
					else begin
						sub_q <= sub_q + 1'b1;
						if (sub_q == 2'd1) begin
							oth_q <= lchild[AW-1:0]; oth_e_q <= slot_rd_q;
							if (!rgt_ok) begin
								sub_q <= '0; state_q <= S_DN_C;
							end
						end
						if (sub_q == 2'd2) begin
							rgt_e_q <= slot_rd_q; sub_q <= '0; state_q <= S_DN_D;
						end
					end
				end
				S_DN_D: begin
					if (oth_e_q[PW-1:0] < rgt_e_q[PW-1:0]) begin
						oth_q <= rchild[AW-1:0]; oth_e_q <= rgt_e_q;
					end
					state_q <= S_DN_C;
				end
				S_DN_C: begin
					if (cur_e_q[PW-1:0] < oth_e_q[PW-1:0]) state_q <= S_CMP;
					else state_q <= S_DONE;
				end
				S_CMP: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						sub_q <= '0;
						cur_q <= oth_q;
						state_q <= (op_q == ibh_pkg::OP_REMOVE) ? S_DN_R : S_UP_R;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// S_DN_R reads left at sub 0, right at sub 1
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign out_node = onode_q;
	assign out_priority = ibh_pkg::REQ_PRIO_W'(oprio_q);
	assign present = opres_q;
	assign entry_count = ibh_pkg::COUNT_W'(fill_q);
	assign status = st_q;
endmodule

// File: tb/heap_scoreboard.sv
// Scoreboard class: heap predictor and queue of expected responses.
`timescale 1ns / 1ps
class heap_scoreboard;
	typedef struct packed {
		logic [9:0]  node;
		logic [15:0] prio;
		logic        pres;
		logic [10:0] count;
		logic [1:0]  stat;
	} resp_t;

	logic [9:0]  ids [1024];
	logic [15:0] prios [1024];
	logic [9:0]  pos_of [1024];
	bit          member [1024];
	int          fill;
	resp_t       pending [$];
	int          errors;

	function new();
		fill = 0;
		errors = 0;
		foreach (member[i]) member[i] = 0;
	endfunction

	function void swap_slots(int a, int b);
		logic [9:0] ia, ib;
		logic [15:0] pa;
		ia = ids[a];
		ib = ids[b];
		pa = prios[a];
		ids[a] = ib;
		ids[b] = ia;
		prios[a] = prios[b];
		prios[b] = pa;
		pos_of[ib] = 10'(a);
		pos_of[ia] = 10'(b);
	endfunction

	function void sift_up(int p);
		int par;
		while (p > 0) begin
			par = (p - 1) / 2;
			if (prios[p] > prios[par]) begin
				swap_slots(p, par);
				p = par;
			end else begin
				return;
			end
		end
	endfunction

	function void sift_down(int p);
		int l, pick;
		forever begin
			l = 2 * p + 1;
			if (l >= fill) return;
			pick = l;
			if (l + 1 < fill && prios[l] < prios[l + 1]) pick = l + 1;
			if (prios[p] < prios[pick]) begin
				swap_slots(p, pick);
				p = pick;
			end else begin
				return;
			end
		end
	endfunction

	function void note_request(logic [1:0] op, logic [9:0] id, logic [15:0] pr);
		resp_t r;
		r = '0;
		r.node = id;
		case (op)
			ibh_pkg::OP_INSERT: begin
				if (fill >= 1024 || member[id]) begin
					r.stat = ibh_pkg::ST_FULL;
				end else begin
					ids[fill] = id;
					prios[fill] = pr;
					pos_of[id] = 10'(fill);
					member[id] = 1;
					fill++;
					sift_up(fill - 1);
				end
			end
			ibh_pkg::OP_REMOVE: begin
				if (fill == 0) begin
					r.stat = ibh_pkg::ST_EMPTY;
				end else begin
					r.node = ids[0];
					r.prio = prios[0];
					member[ids[0]] = 0;
					fill--;
					if (fill > 0) begin
						ids[0] = ids[fill];
						prios[0] = prios[fill];
						pos_of[ids[0]] = 0;
						sift_down(0);
					end
				end
			end
			ibh_pkg::OP_UPDATE: begin
				if (!member[id]) begin
					r.stat = ibh_pkg::ST_ABSENT;
				end else begin
					prios[pos_of[id]] = pr;
					sift_up(pos_of[id]);
				end
			end
			default: r.pres = member[id];
		endcase
		r.count = 11'(fill);
		pending.push_back(r);
	endfunction

	function void check_response(resp_t got);
		resp_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected response %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.node !== e.node)
			$display("%0t: out_node exp %0d got %0d", $time, e.node, got.node);
		if (got.prio !== e.prio)
			$display("%0t: out_priority exp %0d got %0d", $time, e.prio, got.prio);
		if (got.pres !== e.pres)
			$display("%0t: present exp %0d got %0d", $time, e.pres, got.pres);
		if (got.count !== e.count)
			$display("%0t: entry_count exp %0d got %0d", $time, e.count, got.count);
		if (got.stat !== e.stat)
			$display("%0t: status exp %0d got %0d", $time, e.stat, got.stat);
		if (got !== e) errors++;
	endfunction
endclass

// File: tb/tb_top.sv
// Top-level testbench for the indexed binary heap core.
`timescale 1ns / 1ps
module tb_top;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [9:0]  node_id;
	logic [15:0] priority_req;
	logic        done;
	logic [9:0]  out_node;
	logic [15:0] out_priority;
	logic        present;
	logic [10:0] entry_count;
	logic [1:0]  status;

	heap_scoreboard sb;
	int idle_cycles = 0;

	indexed_binary_heap_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .node_id(node_id), .priority_req(priority_req),
		.done(done), .out_node(out_node), .out_priority(out_priority),
		.present(present), .entry_count(entry_count), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_response({out_node, out_priority, present, entry_count, status});
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < 20000) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] op, logic [9:0] id, logic [15:0] pr);
		start <= 1;
		operation <= op;
		node_id <= id;
		priority_req <= pr;
		do @(posedge clk); while (busy);
		sb.note_request(op, id, pr);
		gap();
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic insert_fresh();
		logic [9:0] id;
		id = 10'($urandom);
		while (sb.member[id]) id = id + 10'd1;
		send_request(ibh_pkg::OP_INSERT, id, 16'($urandom));
	endtask

	task automatic random_request(int fill_bias);
		int k;
		logic [9:0] id;
		k = $urandom_range(0, 99);
		id = (sb.fill > 0 && $urandom_range(0, 1)) ? sb.ids[$urandom_range(0, sb.fill - 1)]
			: 10'($urandom);
		if (k < fill_bias)
			send_request(ibh_pkg::OP_INSERT, 10'($urandom), 16'($urandom));
		else if (k < fill_bias + 25)
			send_request(ibh_pkg::OP_REMOVE, 10'($urandom), 16'($urandom));
		else if (k < fill_bias + 40)
			send_request(ibh_pkg::OP_UPDATE, id,
				($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
		else
			send_request(ibh_pkg::OP_QUERY, id, 16'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		operation = ibh_pkg::OP_QUERY;
		node_id = '0;
		priority_req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(ibh_pkg::OP_REMOVE, 10'd5, 16'd0);
		send_request(ibh_pkg::OP_UPDATE, 10'd7, 16'd9);
		send_request(ibh_pkg::OP_QUERY, 10'd0, 16'd0);
		send_request(ibh_pkg::OP_INSERT, 10'd0, 16'd0);
		send_request(ibh_pkg::OP_INSERT, 10'd1023, 16'hFFFF);
		send_request(ibh_pkg::OP_INSERT, 10'd1023, 16'd3);
		send_request(ibh_pkg::OP_INSERT, 10'd300, 16'd100);
		send_request(ibh_pkg::OP_INSERT, 10'd301, 16'd100);
		send_request(ibh_pkg::OP_INSERT, 10'd302, 16'd50);
		send_request(ibh_pkg::OP_QUERY, 10'd1023, 16'hFFFF);
		send_request(ibh_pkg::OP_UPDATE, 10'd302, 16'd200);
		send_request(ibh_pkg::OP_UPDATE, 10'd1023, 16'd1);
		send_request(ibh_pkg::OP_UPDATE, 10'd0, 16'hFFFF);
		send_request(ibh_pkg::OP_QUERY, 10'd999, 16'd0);
		repeat (7) send_request(ibh_pkg::OP_REMOVE, 10'h2AA, 16'h5555);
		send_request(ibh_pkg::OP_QUERY, 10'd300, 16'd0);
		drain();
		repeat (60) @(posedge clk);

		repeat (150) random_request(45);
		drain();
		repeat (60) @(posedge clk);
		while (sb.fill < 1024) begin
			if ($urandom_range(0, 7) == 0) random_request(0);
			else insert_fresh();
		end
		repeat (6) send_request(ibh_pkg::OP_INSERT, 10'($urandom), 16'($urandom));
		repeat (10) random_request(10);
		repeat (25) random_request(30);
		repeat (20) random_request(20);
		drain();
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
